FILE: rtl/kmd_pkg.sv
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared types and constants for the k-way merge engine with duplicate
// elimination (newest run wins).
// ----------------------------------------------------------------------------
package kmd_pkg;

  // Default geometry
  localparam int NUM_RUNS_DEF  = 4;
  localparam int RUN_DEPTH_DEF = 256;

  // Field widths
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int PAY_W   = VAL_W + 1;    // {deleted, value}
  localparam int CNT_W   = 11;
  localparam int RIDX_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Stream widths, padded to whole bytes
  localparam int IN_FIELDS_W  = RIDX_W + KEY_W + VAL_W + 1;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = KEY_W + VAL_W + 1 + CNT_W + CNT_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Command carried on the slave-side tuser
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_PULL = 1'b1
  } cmd_t;

  // Status carried on the master-side tuser
  typedef enum logic {
    ST_RECORD = 1'b0,
    ST_DONE   = 1'b1
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PEND,
    S_REFILL
  } state_t;

endpackage

FILE: rtl/kway_merge_dedup_newest_wins.sv
// ----------------------------------------------------------------------------
// kway_merge_dedup_newest_wins
// Compaction merge engine: sorted runs held in per-run memory banks, merged
// one record per pull with duplicate keys resolved in favor of the newest run.
// ----------------------------------------------------------------------------
// A load item (tuser = load) appends a record to the tail of one run; run 0 is
// the newest. A pull item (tuser = pull) returns the smallest signed head key,
// taken from the lowest-numbered run holding it, and consumes every head with
// that key so older copies disappear; tombstones are passed on and counted.
// When all runs are exhausted a pull returns a done item carrying the final
// counts, then empties all runs and clears the counts. A load into a full run
// is dropped and sets the sticky overflow bit, which only reset clears.
// Steps: a record pull compares the head registers of all runs through a min
// tree while the result is registered and each consumed run's memory bank is
// read; in the refill state that follows, the read word is loaded into that
// run's head register. A done pull has no refill step.
// A pull waits in front of the output register while an earlier result is
// still not taken; the input is held off in that time, so no later load can
// change what the waiting pull returns. There is no clearing pass after
// reset: each run's fill count tells which entries hold data.
// ----------------------------------------------------------------------------
module kway_merge_dedup_newest_wins
  import kmd_pkg::*;
#(
  parameter int NUM_RUNS  = NUM_RUNS_DEF,
  parameter int RUN_DEPTH = RUN_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // slave side
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // fields from bit 0: run_index[1:0], rec_key[33:2], rec_value[65:34],
  // rec_deleted[66], zero pad[71:67]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // fields: cmd[0]
  input  logic                   s_tuser,
  // master side
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // fields from bit 0: out_key[31:0], out_value[63:32], out_deleted[64],
  // written_total[75:65], tombstone_total[86:76], overflow[87]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // fields: status[0]
  output logic                   m_tuser
);

  localparam int AW  = $clog2(RUN_DEPTH);        // bank address width
  localparam int FW  = $clog2(RUN_DEPTH + 1);    // fill / pointer width
  localparam int RW  = $clog2(NUM_RUNS);         // run number width
  localparam int NP  = 2 ** RW;                  // min tree leaves
  localparam int WW  = KEY_W + PAY_W;            // bank word width
  localparam logic [FW-1:0] FULL = FW'(RUN_DEPTH);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t             state, state_next;

  logic [FW-1:0]      fill      [NUM_RUNS];
  logic [FW-1:0]      rptr      [NUM_RUNS];
  logic [KEY_W-1:0]   head_key  [NUM_RUNS];
  logic [PAY_W-1:0]   head_pay  [NUM_RUNS];
  logic [NUM_RUNS-1:0] refill;
  logic [WW-1:0]      rd_word   [NUM_RUNS];

  logic [CNT_W-1:0]   cnt_emit;
  logic [CNT_W-1:0]   cnt_tomb;
  logic               ovf;

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic               s_fire;
  logic               ld;
  logic               pull_acc;
  logic               slot_free;
  logic               do_pull;
  logic [RIDX_W-1:0]  ld_run;
  logic [KEY_W-1:0]   ld_key;
  logic [PAY_W-1:0]   ld_pay;

  assign s_fire    = s_tvalid && s_tready;
  assign ld        = s_fire && (cmd_t'(s_tuser) == CMD_LOAD);
  assign pull_acc  = s_fire && (cmd_t'(s_tuser) == CMD_PULL);
  assign slot_free = !m_tvalid || m_tready;
  assign ld_run    = s_tdata[RIDX_W-1:0];
  assign ld_key    = s_tdata[RIDX_W +: KEY_W];
  assign ld_pay    = s_tdata[RIDX_W + KEY_W +: PAY_W];

  // --------------------------------------------------------------------------
  // Head compare: registered heads feed a min tree; ties go to the left
  // (lower, newer) run.
  // --------------------------------------------------------------------------
  logic [NUM_RUNS-1:0] head_valid;
  logic [NUM_RUNS-1:0] hit;
  logic                any_valid;
  logic [KEY_W-1:0]    best_key;
  logic [RW-1:0]       best_run;
  logic [PAY_W-1:0]    best_pay;

  logic                tv [2*NP];
  logic [KEY_W-1:0]    tk [2*NP];
  logic [RW-1:0]       tr [2*NP];

  always_comb begin
    for (int r = 0; r < NUM_RUNS; r++) begin
      head_valid[r] = rptr[r] < fill[r];
    end
    for (int i = 0; i < 2 * NP; i++) begin
      tv[i] = 1'b0;
      tk[i] = '0;
      tr[i] = '0;
    end
    for (int i = 0; i < NP; i++) begin
      if (i < NUM_RUNS) begin
        tv[NP + i] = head_valid[i];
        tk[NP + i] = head_key[i];
        tr[NP + i] = RW'(i);
      end
    end
    for (int n = NP - 1; n >= 1; n--) begin
      if (tv[2*n] && (!tv[2*n+1] || ($signed(tk[2*n]) <= $signed(tk[2*n+1])))) begin
        tv[n] = tv[2*n];
        tk[n] = tk[2*n];
        tr[n] = tr[2*n];
      end else begin
        tv[n] = tv[2*n+1];
        tk[n] = tk[2*n+1];
        tr[n] = tr[2*n+1];
      end
    end
    any_valid = tv[1];
    best_key  = tk[1];
    best_run  = tr[1];
    best_pay  = head_pay[best_run];
    for (int r = 0; r < NUM_RUNS; r++) begin
      hit[r] = head_valid[r] && (head_key[r] == best_key);
    end
  end

  // Counts after the record now being emitted
  logic [CNT_W-1:0] emit_inc;
  logic [CNT_W-1:0] tomb_inc;

  always_comb begin
    emit_inc = (cnt_emit == CNT_MAX) ? cnt_emit : cnt_emit + 1'b1;
    tomb_inc = (best_pay[VAL_W] && (cnt_tomb != CNT_MAX)) ? cnt_tomb + 1'b1 : cnt_tomb;
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pull_acc) begin
          if (!slot_free) state_next = S_PEND;
          else if (any_valid) state_next = S_REFILL;
        end
      end
      S_PEND: begin
        if (slot_free) state_next = any_valid ? S_REFILL : S_IDLE;
      end
      S_REFILL: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    s_tready = 1'b0;
    do_pull  = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        do_pull  = pull_acc && slot_free;
      end
      S_PEND: begin
        do_pull = slot_free;
      end
      S_REFILL: begin
        s_tready = 1'b0;
      end
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Run banks: one write port (append), one read port (head refill)
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < NUM_RUNS; g++) begin : g_bank
    logic [WW-1:0] mem [RUN_DEPTH];
    logic [FW-1:0] nxt_ptr;
    logic          wr_en;

    assign nxt_ptr = rptr[g] + 1'b1;
    assign wr_en   = ld && (int'(ld_run) == g) && (fill[g] != FULL);

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[fill[g][AW-1:0]] <= {ld_pay, ld_key};
      end
      if (do_pull && hit[g]) begin
        rd_word[g] <= mem[nxt_ptr[AW-1:0]];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Run bookkeeping and head registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_RUNS; r++) begin
        fill[r] <= '0;
        rptr[r] <= '0;
      end
      refill   <= '0;
      cnt_emit <= '0;
      cnt_tomb <= '0;
      ovf      <= 1'b0;
    end else begin
      // append: bump fill or flag a full run (empty-head capture is in the head block)
      if (ld) begin
        for (int r = 0; r < NUM_RUNS; r++) begin
          if (int'(ld_run) == r) begin
            if (fill[r] == FULL) begin
              ovf <= 1'b1;
            end else begin
              fill[r] <= fill[r] + 1'b1;
            end
          end
        end
      end
      if (do_pull) begin
        if (any_valid) begin
          // advance every run whose head matches; older copies drop out
          for (int r = 0; r < NUM_RUNS; r++) begin
            if (hit[r]) rptr[r] <= rptr[r] + 1'b1;
          end
          refill   <= hit;
          cnt_emit <= emit_inc;
          cnt_tomb <= tomb_inc;
        end else begin
          for (int r = 0; r < NUM_RUNS; r++) begin
            fill[r] <= '0;
            rptr[r] <= '0;
          end
          cnt_emit <= '0;
          cnt_tomb <= '0;
        end
      end
      if (state == S_REFILL) begin
        refill <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < NUM_RUNS; r++) begin
      if (ld && (int'(ld_run) == r) && (fill[r] != FULL) && (rptr[r] == fill[r])) begin
        head_key[r] <= ld_key;
        head_pay[r] <= ld_pay;
      end else if ((state == S_REFILL) && refill[r]) begin
        head_key[r] <= rd_word[r][KEY_W-1:0];
        head_pay[r] <= rd_word[r][KEY_W +: PAY_W];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_pull) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pull) begin
      if (any_valid) begin
        m_tuser <= ST_RECORD;
        m_tdata <= OUT_TDATA_W'({ovf, tomb_inc, emit_inc, best_pay, best_key});
      end else begin
        m_tuser <= ST_DONE;
        m_tdata <= OUT_TDATA_W'({ovf, cnt_tomb, cnt_emit, 1'b0,
                                 {VAL_W{1'b0}}, {KEY_W{1'b0}}});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_refill_after_pull: assert property (@(posedge clk) disable iff (rst)
    (state == S_REFILL) |-> ($past(do_pull) && $past(any_valid)))
    else $error("head refill without a preceding record pull");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    ovf |=> ovf)
    else $error("overflow flag cleared without reset");

  a_no_load_in_refill: assert property (@(posedge clk) disable iff (rst)
    (state == S_REFILL) |-> !s_tready)
    else $error("item accepted while heads are refilling");

  for (genvar g = 0; g < NUM_RUNS; g++) begin : g_chk
    a_ptr_le_fill: assert property (@(posedge clk) disable iff (rst)
      (rptr[g] <= fill[g]) && (fill[g] <= FULL))
      else $error("run read pointer passed its fill count");
  end

endmodule

FILE: bench/tb_kway_merge_dedup_newest_wins.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kway_merge_dedup_newest_wins
// Self-checking bench for the k-way merge engine: drives load and pull items
// with random gaps and back-pressure, predicts every merged record or done
// item in a tracker class and compares each output item field by field.
// ----------------------------------------------------------------------------
module tb_kway_merge_dedup_newest_wins;
  import kmd_pkg::*;

  localparam int NUM_RUNS    = NUM_RUNS_DEF;
  localparam int RUN_DEPTH   = RUN_DEPTH_DEF;
  localparam int ITEM_TARGET = 1550;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 20;
  localparam int CYCLE_LIMIT = 800000;
  localparam int PRINT_CAP   = 60;

  localparam longint KEY_MIN = -64'sd2147483648;
  localparam longint KEY_MAX = 64'sd2147483647;

  // Output field offsets inside m_tdata
  localparam int OFF_VAL = KEY_W;
  localparam int OFF_DEL = KEY_W + VAL_W;
  localparam int OFF_WR  = OFF_DEL + 1;
  localparam int OFF_TB  = OFF_WR + CNT_W;
  localparam int OFF_OV  = OFF_TB + CNT_W;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  typedef struct {
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             deleted;
    logic [CNT_W-1:0] written;
    logic [CNT_W-1:0] tombs;
    logic             ovf;
  } merge_rec_t;

  // Tracks the run contents and predicts what each pull returns.
  class dedup_merge_tracker;
    logic [KEY_W-1:0] run_keys    [NUM_RUNS*RUN_DEPTH];
    logic [PAY_W-1:0] run_payload [NUM_RUNS*RUN_DEPTH];
    int               fill        [NUM_RUNS];
    int               rd_ptr      [NUM_RUNS];
    logic [CNT_W-1:0] emitted;
    logic [CNT_W-1:0] tombs;
    logic             ovf;
    merge_rec_t       pending_records[$];
    int               errors;

    function new();
      for (int r = 0; r < NUM_RUNS; r++) begin
        fill[r]   = 0;
        rd_ptr[r] = 0;
      end
      emitted = '0;
      tombs   = '0;
      ovf     = 1'b0;
      errors  = 0;
    endfunction

    function bit exhausted();
      for (int r = 0; r < NUM_RUNS; r++)
        if (rd_ptr[r] < fill[r]) return 1'b0;
      return 1'b1;
    endfunction

    function void note_item(cmd_t cmd, logic [RIDX_W-1:0] run, logic [KEY_W-1:0] key,
                            logic [VAL_W-1:0] val, logic del);
      merge_rec_t       rec;
      bit               found;
      int               best;
      logic [KEY_W-1:0] best_key;
      logic [PAY_W-1:0] pay;
      int               slot;
      found    = 1'b0;
      best     = 0;
      best_key = '0;
      if (cmd == CMD_LOAD) begin
        // drop an append to a full run and latch the overflow
        if (fill[run] >= RUN_DEPTH) begin
          ovf = 1'b1;
          return;
        end
        slot = int'(run) * RUN_DEPTH + fill[run];
        run_keys[slot]    = key;
        run_payload[slot] = {del, val};
        fill[run]++;
        return;
      end
      for (int r = 0; r < NUM_RUNS; r++) begin
        if (rd_ptr[r] < fill[r]) begin
          slot = r * RUN_DEPTH + rd_ptr[r];
          if (!found || $signed(run_keys[slot]) < $signed(best_key)) begin
            found    = 1'b1;
            best     = r;
            best_key = run_keys[slot];
          end
        end
      end
      if (!found) begin
        rec.status  = ST_DONE;
        rec.key     = '0;
        rec.value   = '0;
        rec.deleted = 1'b0;
        rec.written = emitted;
        rec.tombs   = tombs;
        rec.ovf     = ovf;
        for (int r = 0; r < NUM_RUNS; r++) begin
          fill[r]   = 0;
          rd_ptr[r] = 0;
        end
        emitted = '0;
        tombs   = '0;
      end else begin
        pay = run_payload[best * RUN_DEPTH + rd_ptr[best]];
        // consume every head holding the winning key, older copies vanish
        for (int r = 0; r < NUM_RUNS; r++)
          if (rd_ptr[r] < fill[r] && run_keys[r * RUN_DEPTH + rd_ptr[r]] == best_key)
            rd_ptr[r]++;
        if (emitted < CNT_MAX) emitted++;
        if (pay[PAY_W-1] && tombs < CNT_MAX) tombs++;
        rec.status  = ST_RECORD;
        rec.key     = best_key;
        rec.value   = pay[VAL_W-1:0];
        rec.deleted = pay[PAY_W-1];
        rec.written = emitted;
        rec.tombs   = tombs;
        rec.ovf     = ovf;
      end
      pending_records.push_back(rec);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] data, logic user);
      merge_rec_t want;
      if (pending_records.size() == 0) begin
        report($sformatf("output item with nothing expected, tdata=%h", data));
        return;
      end
      want = pending_records.pop_front();
      if (user !== want.status)
        report($sformatf("status %b, want %b", user, want.status));
      if (data[KEY_W-1:0] !== want.key)
        report($sformatf("out_key %h, want %h", data[KEY_W-1:0], want.key));
      if (data[OFF_VAL +: VAL_W] !== want.value)
        report($sformatf("out_value %h, want %h", data[OFF_VAL +: VAL_W], want.value));
      if (data[OFF_DEL] !== want.deleted)
        report($sformatf("out_deleted %b, want %b", data[OFF_DEL], want.deleted));
      if (data[OFF_WR +: CNT_W] !== want.written)
        report($sformatf("written_total %0d, want %0d", data[OFF_WR +: CNT_W], want.written));
      if (data[OFF_TB +: CNT_W] !== want.tombs)
        report($sformatf("tombstone_total %0d, want %0d", data[OFF_TB +: CNT_W], want.tombs));
      if (data[OFF_OV] !== want.ovf)
        report($sformatf("overflow %b, want %b", data[OFF_OV], want.ovf));
    endtask
  endclass

  dedup_merge_tracker sb = new();

  int cycle_count = 0;
  int items_sent  = 0;
  bit tx_no_idle  = 1'b0;
  bit rx_no_idle  = 1'b0;
  bit hold_req    = 1'b0;

  kway_merge_dedup_newest_wins #(
    .NUM_RUNS  (NUM_RUNS),
    .RUN_DEPTH (RUN_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] clamp_key(longint v);
    if (v > KEY_MAX) return KEY_MAX[KEY_W-1:0];
    if (v < KEY_MIN) return KEY_MIN[KEY_W-1:0];
    return v[KEY_W-1:0];
  endfunction

  // Offer one item from a falling edge, hold it until the handshake, then
  // note it in the tracker. Returns on the falling edge after acceptance.
  task automatic send_item(cmd_t cmd, logic [RIDX_W-1:0] run, logic [KEY_W-1:0] key,
                           logic [VAL_W-1:0] val, logic del);
    int gap;
    gap = (tx_no_idle || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = IN_TDATA_W'({del, val, key, run});
    do @(posedge clk); while (!s_tready);
    sb.note_item(cmd, run, key, val, del);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_load(int run, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val, logic del);
    send_item(CMD_LOAD, RIDX_W'(run), key, val, del);
  endtask

  // Pull with random filler on the data lanes; the block must ignore it.
  task automatic send_pull();
    send_item(CMD_PULL, RIDX_W'($urandom_range(0, 3)), $urandom(), $urandom(),
              1'($urandom_range(0, 1)));
  endtask

  // One merge: fill the runs with non-decreasing keys in random interleaving,
  // sprinkle in out-of-order noise and early pulls, then pull, with some stray loads, until done.
  task automatic run_merge(int mode, int max_per_run, int big_run, bit pressure);
    int          left [NUM_RUNS];
    longint      cur  [NUM_RUNS];
    int          total;
    int          pick;
    int          load_pct;
    logic [31:0] step;
    total = 0;
    for (int r = 0; r < NUM_RUNS; r++) begin
      left[r] = (r == big_run) ? RUN_DEPTH + 2 : $urandom_range(0, max_per_run);
      case (mode)
        0:       cur[r] = longint'($signed($urandom()));
        1:       cur[r] = longint'($urandom_range(0, 16)) - 8;
        default: cur[r] = KEY_MIN + longint'($urandom_range(0, 2));
      endcase
      total += left[r];
    end
    while (total > 0) begin
      if ($urandom_range(0, 99) < 6)
        send_load($urandom_range(0, NUM_RUNS - 1), $urandom(), $urandom(),
                  1'($urandom_range(0, 1)));
      if ($urandom_range(0, 99) < 5) send_pull();
      pick = $urandom_range(0, NUM_RUNS - 1);
      while (left[pick] == 0) pick = (pick + 1) % NUM_RUNS;
      send_load(pick, clamp_key(cur[pick]), $urandom(), $urandom_range(0, 3) == 0);
      case (mode)
        0:       step = $urandom_range(1, 1 << 26);
        1:       step = $urandom_range(0, 3);
        default: step = $urandom_range(1, 32'h7fff_ffff);
      endcase
      cur[pick] = cur[pick] + longint'(step);
      if (cur[pick] > KEY_MAX) cur[pick] = KEY_MAX;
      left[pick]--;
      total--;
    end
    // Under pressure: stop the receiver for a long stretch and keep offering
    // items back to back so the output fills and the input stalls.
    if (pressure) begin
      hold_req   = 1'b1;
      tx_no_idle = 1'b1;
    end
    load_pct = pressure ? 30 : 4;
    while (!sb.exhausted()) begin
      if ($urandom_range(0, 99) < load_pct)
        send_load($urandom_range(0, NUM_RUNS - 1), $urandom(), $urandom(),
                  1'($urandom_range(0, 1)));
      else
        send_pull();
    end
    send_pull();
    if ($urandom_range(0, 99) < 15) send_pull();
  endtask

  // Receiver: random ready with gaps, honoring a long hold-off on request.
  initial begin
    int wait_left;
    wait_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (rx_no_idle) begin
        m_tready = 1'b1;
      end else if (wait_left > 0) begin
        m_tready = 1'b0;
        wait_left--;
      end else begin
        m_tready = 1'b1;
        if ($urandom_range(0, 5) == 0) wait_left = pick_gap();
      end
    end
  end

  // Check every accepted output item against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("kway_merge_dedup_newest_wins test failed");
      $finish;
    end
  end

  initial begin
    int  merge_idx;
    bit  overflow_done;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_LOAD;
    merge_idx = 0;
    overflow_done = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: pull on empty runs gives done with zero counts
    send_pull();
    // key extremes, cross-run duplicates, tombstones
    send_load(0, KEY_MIN[31:0], 32'h7fff_ffff, 1'b0);
    send_load(1, KEY_MIN[31:0], 32'h8000_0000, 1'b1);
    send_load(2, KEY_MAX[31:0], 32'h8000_0000, 1'b1);
    send_load(3, 32'd5, 32'd123, 1'b0);
    send_load(3, KEY_MAX[31:0], 32'hffff_ffff, 1'b0);
    send_load(1, 32'd5, 32'd7, 1'b1);
    send_pull();
    // append during the merge, lands behind the consumed head
    send_load(0, 32'd3, 32'd0, 1'b0);
    send_pull();
    send_pull();
    send_pull();
    send_pull();
    send_pull();
    // unsorted run and a duplicate key inside one run
    send_load(0, 32'd10, 32'd1, 1'b0);
    send_load(0, 32'd2, 32'd2, 1'b1);
    send_load(1, 32'd5, 32'd3, 1'b0);
    send_load(1, 32'd5, 32'd4, 1'b0);
    repeat (5) send_pull();

    // Random merges; one fills a run past its depth, one runs under pressure
    while (items_sent < ITEM_TARGET) begin
      tx_no_idle = (merge_idx % 5 == 4);
      rx_no_idle = tx_no_idle;
      if (!overflow_done && items_sent >= 700) begin
        run_merge(1, 4, $urandom_range(0, NUM_RUNS - 1), 1'b0);
        overflow_done = 1'b1;
      end else begin
        run_merge(merge_idx % 3, (merge_idx % 3 == 0) ? 16 : 10, -1, merge_idx == 2);
      end
      merge_idx++;
    end
    s_tvalid   = 1'b0;
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;

    // Drain, then give stray output items a chance to show up
    while (sb.pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending_records.size() == 0)
      $display("kway_merge_dedup_newest_wins test passed");
    else
      $display("kway_merge_dedup_newest_wins test failed");
    $finish;
  end

endmodule
